### design/srcp_pkg.sv
// Shared types and constants for the servo range calibrating positioner.
package srcp_pkg;

  // Field widths
  localparam int SAMPLE_W = 10;  // used bits of the converter reading
  localparam int SENSOR_W = 10;  // sensor_sample field width
  localparam int USE_W    = (SAMPLE_W < SENSOR_W) ? SAMPLE_W : SENSOR_W;
  localparam int ANGLE_W  = 8;
  localparam int HOLD_W   = 16;
  localparam int BEEP_W   = 3;
  localparam int MODE_W   = 2;

  // Divider sizing: dividend up to 2^SAMPLE_W
  localparam int DIV_W = SAMPLE_W + 1;
  localparam int CNT_W = $clog2(DIV_W);

  // Angle constants
  localparam logic [ANGLE_W-1:0] ANGLE_MID   = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP  = 8'd5;
  localparam logic [ANGLE_W-1:0] ANGLE_TOP   = 8'd175;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [ANGLE_W-1:0] MIN_RESET   = 8'd45;
  localparam logic [ANGLE_W-1:0] MAX_RESET   = 8'd135;
  localparam logic [HOLD_W-1:0]  LONG_RESET  = 16'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_RUN = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } mode_t;

  typedef enum logic [BEEP_W-1:0] {
    BEEP_NONE  = 3'd0,
    BEEP_PRESS = 3'd1,
    BEEP_LONG  = 3'd2,
    BEEP_ENTER = 3'd3,
    BEEP_EXIT  = 3'd4
  } beep_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_SPAN,
    ST_DIV_SAMPLE,
    ST_MAP,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_load_sample;
    logic map;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

### design/srcp_in_if.sv
// Input channel: one tick word with button level and sensor sample.
interface srcp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         button_level;
  logic [srcp_pkg::SENSOR_W-1:0] sensor_sample;

  modport source (output valid, output button_level, output sensor_sample, input ready);
  modport sink   (input valid, input button_level, input sensor_sample, output ready);
endinterface

### design/srcp_out_if.sv
// Result channel: angle, LED, beep code, mode and fault per tick.
interface srcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [srcp_pkg::ANGLE_W-1:0] servo_angle;
  logic                        led_on;
  logic [srcp_pkg::BEEP_W-1:0]  beep_code;
  logic [srcp_pkg::MODE_W-1:0]  mode_now;
  logic                        range_fault;

  modport source (output valid, output servo_angle, output led_on, output beep_code,
                  output mode_now, output range_fault, input ready);
  modport sink   (input valid, input servo_angle, input led_on, input beep_code,
                  input mode_now, input range_fault, output ready);
endinterface

### design/srcp_ctrl.sv
// Controller state machine: sequences accept, the two divides, mapping and emit.
module srcp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srcp_pkg::ctrl_sts_t sts,
  output srcp_pkg::ctrl_cmd_t cmd
);

  srcp_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srcp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srcp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_div ? srcp_pkg::ST_DIV_SPAN : srcp_pkg::ST_EMIT;
        end
      end
      srcp_pkg::ST_DIV_SPAN: begin
        if (sts.div_last) state_nxt = srcp_pkg::ST_DIV_SAMPLE;
      end
      srcp_pkg::ST_DIV_SAMPLE: begin
        if (sts.div_last) state_nxt = srcp_pkg::ST_MAP;
      end
      srcp_pkg::ST_MAP: begin
        state_nxt = srcp_pkg::ST_EMIT;
      end
      srcp_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = srcp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = srcp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      srcp_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      srcp_pkg::ST_DIV_SPAN: begin
        cmd.div_step        = ~sts.div_last;
        cmd.div_load_sample = sts.div_last;
      end
      srcp_pkg::ST_DIV_SAMPLE: begin
        cmd.div_step = 1'b1;
      end
      srcp_pkg::ST_MAP: begin
        cmd.map = 1'b1;
      end
      srcp_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### design/srcp_datapath.sv
// Datapath: button classifier, calibration state, shared divider, output register.
module srcp_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [srcp_pkg::HOLD_W-1:0]     cfg_wr_data,
  input  logic                            in_button_level,
  input  logic [srcp_pkg::SENSOR_W-1:0]   in_sensor_sample,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [srcp_pkg::ANGLE_W-1:0]    out_servo_angle,
  output logic                            out_led_on,
  output logic [srcp_pkg::BEEP_W-1:0]     out_beep_code,
  output logic [srcp_pkg::MODE_W-1:0]     out_mode_now,
  output logic                            out_range_fault,
  input  srcp_pkg::ctrl_cmd_t             cmd,
  output srcp_pkg::ctrl_sts_t             sts
);

  localparam int DW = srcp_pkg::DIV_W;
  localparam int AW = srcp_pkg::ANGLE_W;
  localparam int HW = srcp_pkg::HOLD_W;

  // Architectural state
  logic [HW-1:0]     long_ticks_r;
  srcp_pkg::mode_t   mode_r, mode_nxt;
  logic [AW-1:0]     angle_r, angle_nxt;
  logic [AW-1:0]     min_r, min_nxt;
  logic [AW-1:0]     max_r, max_nxt;
  logic [HW-1:0]     hold_r, hold_nxt;
  logic              was_r, was_nxt;
  logic              long_r, long_nxt;

  // Pending result fields
  srcp_pkg::beep_t   beep_pend_r, beep_nxt;
  logic              fault_pend_r, fault_nxt;
  logic [srcp_pkg::USE_W-1:0] sample_r;

  // Divider
  logic [DW-1:0]     rem_r, quo_r, dvs_r;
  logic [srcp_pkg::CNT_W-1:0] cnt_r;
  logic [DW:0]       shifted;
  logic              ge;
  logic [DW-1:0]     rem_step, quo_step, dvs_sample;

  // Output register
  logic              out_valid_r;
  logic [AW-1:0]     out_angle_r;
  logic              out_led_r;
  logic [srcp_pkg::BEEP_W-1:0] out_beep_r;
  logic [srcp_pkg::MODE_W-1:0] out_mode_r;
  logic              out_fault_r;

  // Classifier and mode logic
  logic [HW-1:0]     thr, hold_inc;
  logic              ev_any, ev_long, map_req;
  logic [AW-1:0]     step_angle;
  logic [AW-1:0]     span;
  logic [AW:0]       map_sum_w;
  logic [DW:0]       map_sum;
  logic [AW-1:0]     map_angle;

  always_comb begin
    thr      = (long_ticks_r == '0) ? HW'(1) : long_ticks_r;
    hold_inc = (hold_r == {HW{1'b1}}) ? hold_r : hold_r + HW'(1);
    hold_nxt = hold_r;
    was_nxt  = was_r;
    long_nxt = long_r;
    beep_nxt = srcp_pkg::BEEP_NONE;
    ev_any   = 1'b0;
    ev_long  = 1'b0;
    // press timing
    if (in_button_level) begin
      if (!was_r) begin
        was_nxt  = 1'b1;
        hold_nxt = '0;
        long_nxt = 1'b0;
        beep_nxt = srcp_pkg::BEEP_PRESS;
      end else begin
        hold_nxt = hold_inc;
        if (!long_r && hold_inc >= thr) begin
          long_nxt = 1'b1;
          beep_nxt = srcp_pkg::BEEP_LONG;
        end
      end
    end else if (was_r) begin
      ev_any   = 1'b1;
      ev_long  = long_r;
      was_nxt  = 1'b0;
      long_nxt = 1'b0;
      hold_nxt = '0;
    end

    // mode handling
    mode_nxt   = mode_r;
    angle_nxt  = angle_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    map_req    = 1'b0;
    step_angle = angle_r;
    unique case (mode_r)
      srcp_pkg::MODE_MIN: begin
        if (ev_any) begin
          step_angle = (angle_r >= srcp_pkg::ANGLE_STEP) ? angle_r - srcp_pkg::ANGLE_STEP
                                                         : angle_r;
          min_nxt   = step_angle;
          angle_nxt = step_angle;
          if (ev_long) begin
            mode_nxt  = srcp_pkg::MODE_MAX;
            angle_nxt = srcp_pkg::ANGLE_MID;
          end
        end
      end
      srcp_pkg::MODE_MAX: begin
        if (ev_any) begin
          step_angle = (angle_r <= srcp_pkg::ANGLE_TOP) ? angle_r + srcp_pkg::ANGLE_STEP
                                                        : angle_r;
          max_nxt   = step_angle;
          angle_nxt = step_angle;
          if (ev_long) begin
            mode_nxt = srcp_pkg::MODE_RUN;
            beep_nxt = srcp_pkg::BEEP_EXIT;
            map_req  = 1'b1;
          end
        end
      end
      default: begin
        if (ev_long) begin
          mode_nxt  = srcp_pkg::MODE_MIN;
          angle_nxt = srcp_pkg::ANGLE_MID;
          beep_nxt  = srcp_pkg::BEEP_ENTER;
        end else begin
          mode_nxt = srcp_pkg::MODE_RUN;
          map_req  = 1'b1;
        end
      end
    endcase

    // empty range holds at the minimum
    fault_nxt = map_req && (max_nxt <= min_nxt);
    if (fault_nxt) angle_nxt = min_nxt;
    span = max_nxt - min_nxt;
  end

  // Divider step: one quotient bit per cycle
  always_comb begin
    shifted    = {rem_r, quo_r[DW-1]};
    ge         = shifted >= {1'b0, dvs_r};
    rem_step   = ge ? DW'(shifted - {1'b0, dvs_r}) : shifted[DW-1:0];
    quo_step   = {quo_r[DW-2:0], ge};
    dvs_sample = (quo_step == '0) ? DW'(1) : quo_step;
  end

  // Mapped angle with saturation
  always_comb begin
    map_sum_w = {1'b0, min_r};
    map_sum   = (DW+1)'(map_sum_w) + {1'b0, quo_r};
    map_angle = (map_sum > (DW+1)'(srcp_pkg::ANGLE_MAX)) ? srcp_pkg::ANGLE_MAX
                                                        : map_sum[AW-1:0];
  end

  // Control and calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= srcp_pkg::LONG_RESET;
      mode_r       <= srcp_pkg::MODE_RUN;
      angle_r      <= srcp_pkg::ANGLE_MID;
      min_r        <= srcp_pkg::MIN_RESET;
      max_r        <= srcp_pkg::MAX_RESET;
      hold_r       <= '0;
      was_r        <= 1'b0;
      long_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) long_ticks_r <= cfg_wr_data;
      if (cmd.accept) begin
        mode_r  <= mode_nxt;
        angle_r <= angle_nxt;
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        hold_r  <= hold_nxt;
        was_r   <= was_nxt;
        long_r  <= long_nxt;
      end else if (cmd.map) begin
        angle_r <= map_angle;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pending fields, divider and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      beep_pend_r  <= beep_nxt;
      fault_pend_r <= fault_nxt;
      sample_r     <= in_sensor_sample[srcp_pkg::USE_W-1:0];
      // first divide: 2^SAMPLE_W / span
      rem_r <= '0;
      quo_r <= {1'b1, {srcp_pkg::SAMPLE_W{1'b0}}};
      dvs_r <= DW'(span);
      cnt_r <= '0;
    end else if (cmd.div_load_sample) begin
      // second divide: sample / first quotient
      rem_r <= '0;
      quo_r <= DW'(sample_r);
      dvs_r <= dvs_sample;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      quo_r <= quo_step;
      cnt_r <= cnt_r + srcp_pkg::CNT_W'(1);
    end
    if (cmd.emit) begin
      out_angle_r <= angle_r;
      out_led_r   <= (mode_r == srcp_pkg::MODE_MIN) || (mode_r == srcp_pkg::MODE_MAX);
      out_beep_r  <= beep_pend_r;
      out_mode_r  <= mode_r;
      out_fault_r <= fault_pend_r;
    end
  end

  // Status
  assign sts.need_div = map_req && !fault_nxt;
  assign sts.div_last = (cnt_r == srcp_pkg::CNT_W'(DW - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_servo_angle = out_angle_r;
  assign out_led_on      = out_led_r;
  assign out_beep_code   = out_beep_r;
  assign out_mode_now    = out_mode_r;
  assign out_range_fault = out_fault_r;

endmodule

### design/servo_range_calibrating_positioner.sv
// Servo range calibrating positioner: top level joining controller and datapath.
// A tick that needs no divide goes from acceptance straight to emit; a mapped run
//   tick first runs the shared one-bit-per-cycle divider twice (range divisor, then
//   sample quotient), then maps the angle before emit.
// Throughput: one tick at a time; the next tick is taken while the last word waits.
// Reset: synchronous active-low rst_n restores run mode, angle 90, range 45..135, 1000 ticks.
module servo_range_calibrating_positioner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [srcp_pkg::HOLD_W-1:0]   cfg_wr_data,
  srcp_in_if.sink                       in_ch,
  srcp_out_if.source                    out_ch
);

  srcp_pkg::ctrl_cmd_t cmd;
  srcp_pkg::ctrl_sts_t sts;

  // Sequencer
  srcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  srcp_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_button_level  (in_ch.button_level),
    .in_sensor_sample (in_ch.sensor_sample),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_servo_angle  (out_ch.servo_angle),
    .out_led_on       (out_ch.led_on),
    .out_beep_code    (out_ch.beep_code),
    .out_mode_now     (out_ch.mode_now),
    .out_range_fault  (out_ch.range_fault),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

### tb/sv/servo_range_calibrating_positioner_tb.sv
// Testbench for the servo range calibrating positioner: directed and random tick traffic against a predictor.
`timescale 1ns / 100ps

module servo_range_calibrating_positioner_tb;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving before the run gives up
  localparam int PHASE_TICKS = 200;   // random ticks per hold-limit setting

  // One result word as it appears on the output channel
  typedef struct packed {
    logic [srcp_pkg::ANGLE_W-1:0] angle;
    logic                         led;
    logic [srcp_pkg::BEEP_W-1:0]  beep;
    logic [srcp_pkg::MODE_W-1:0]  mode;
    logic                         fault;
  } tick_word_t;

  typedef enum int {PR_NONE, PR_SHORT, PR_LONG} press_t;

  // Tracks the positioner state and the words it owes
  class tick_scoreboard;
    srcp_pkg::mode_t              mode;
    logic [srcp_pkg::ANGLE_W-1:0] angle;
    logic [srcp_pkg::ANGLE_W-1:0] min_a;
    logic [srcp_pkg::ANGLE_W-1:0] max_a;
    logic [srcp_pkg::HOLD_W-1:0]  hold;
    logic [srcp_pkg::HOLD_W-1:0]  thr;
    bit                           pressed;
    bit                           long_hit;
    tick_word_t                   owed[$];
    int                           mismatches;

    function new();
      mode       = srcp_pkg::MODE_RUN;
      angle      = srcp_pkg::ANGLE_MID;
      min_a      = srcp_pkg::MIN_RESET;
      max_a      = srcp_pkg::MAX_RESET;
      hold       = '0;
      thr        = srcp_pkg::LONG_RESET;
      pressed    = 0;
      long_hit   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Run-mode mapping of a sample into the calibrated range
    function logic [srcp_pkg::ANGLE_W-1:0] map_sample(int smp, output bit flt);
      int span;
      int dv;
      int a;
      if (max_a <= min_a) begin
        flt = 1;
        return min_a;
      end
      flt  = 0;
      span = int'(max_a) - int'(min_a);
      dv   = (1 << srcp_pkg::SAMPLE_W) / span;
      if (dv == 0) dv = 1;
      a = int'(min_a) + smp / dv;
      return (a > int'(srcp_pkg::ANGLE_MAX)) ? srcp_pkg::ANGLE_MAX : srcp_pkg::ANGLE_W'(a);
    endfunction

    // Advance the state by one accepted tick and queue its word
    function void note_tick(bit lvl, logic [srcp_pkg::SENSOR_W-1:0] raw);
      int              smp;
      int              thr_eff;
      srcp_pkg::beep_t bp;
      press_t          ev;
      bit              flt;
      tick_word_t      w;
      smp     = int'(raw) % (1 << srcp_pkg::SAMPLE_W);
      thr_eff = (thr == 0) ? 1 : int'(thr);
      bp      = srcp_pkg::BEEP_NONE;
      ev      = PR_NONE;
      flt     = 0;

      // button classifier
      if (lvl) begin
        if (!pressed) begin
          pressed  = 1;
          hold     = '0;
          long_hit = 0;
          bp       = srcp_pkg::BEEP_PRESS;
        end else begin
          if (hold != {srcp_pkg::HOLD_W{1'b1}}) hold++;
          if (!long_hit && int'(hold) >= thr_eff) begin
            long_hit = 1;
            bp       = srcp_pkg::BEEP_LONG;
          end
        end
      end else if (pressed) begin
        ev       = long_hit ? PR_LONG : PR_SHORT;
        pressed  = 0;
        long_hit = 0;
        hold     = '0;
      end

      // mode handling
      case (mode)
        srcp_pkg::MODE_MIN: begin
          if (ev != PR_NONE) begin
            if (angle >= srcp_pkg::ANGLE_STEP) angle -= srcp_pkg::ANGLE_STEP;
            min_a = angle;
            if (ev == PR_LONG) begin
              mode  = srcp_pkg::MODE_MAX;
              angle = srcp_pkg::ANGLE_MID;
            end
          end
        end
        srcp_pkg::MODE_MAX: begin
          if (ev != PR_NONE) begin
            if (angle <= srcp_pkg::ANGLE_TOP) angle += srcp_pkg::ANGLE_STEP;
            max_a = angle;
            if (ev == PR_LONG) begin
              mode  = srcp_pkg::MODE_RUN;
              bp    = srcp_pkg::BEEP_EXIT;
              angle = map_sample(smp, flt);
            end
          end
        end
        default: begin
          if (ev == PR_LONG) begin
            mode  = srcp_pkg::MODE_MIN;
            angle = srcp_pkg::ANGLE_MID;
            bp    = srcp_pkg::BEEP_ENTER;
          end else begin
            mode  = srcp_pkg::MODE_RUN;
            angle = map_sample(smp, flt);
          end
        end
      endcase

      w.angle = angle;
      w.led   = (mode != srcp_pkg::MODE_RUN);
      w.beep  = bp;
      w.mode  = mode;
      w.fault = flt;
      owed.push_back(w);
    endfunction

    // Compare one output word with the oldest owed word
    function void check_word(tick_word_t got);
      tick_word_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word with nothing owed: angle %0d beep %0d mode %0d",
                   $realtime, got.angle, got.beep, got.mode);
        return;
      end
      want = owed.pop_front();
      if (got.angle !== want.angle || got.led !== want.led || got.beep !== want.beep ||
          got.mode !== want.mode || got.fault !== want.fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp/got ang %0d/%0d led %0b/%0b beep %0d/%0d mode %0d/%0d flt %0b/%0b",
                   $realtime, want.angle, got.angle, want.led, got.led, want.beep, got.beep,
                   want.mode, got.mode, want.fault, got.fault);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [srcp_pkg::HOLD_W-1:0] cfg_wr_data;

  srcp_in_if  in_ch();
  srcp_out_if out_ch();

  servo_range_calibrating_positioner u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  tick_scoreboard sb;
  int burst_left  = 0;
  int ticks_sent  = 0;
  int idle_cycles = 0;
  int rx_cyc      = 0;
  int rx_style    = 0;
  int stall_left  = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drives ready in one of four randomly chosen stall styles
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 256 == 0) rx_style <= $urandom_range(0, 3);
    case (rx_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      2: out_ch.ready <= (rx_cyc % 4 == 0);
      default: begin
        if (stall_left != 0) begin
          out_ch.ready <= 1'b0;
          stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          out_ch.ready <= 1'b0;
          stall_left   <= $urandom_range(1, 20);
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // Output monitor
  always @(posedge clk) begin : word_mon
    tick_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.servo_angle, out_ch.led_on, out_ch.beep_code, out_ch.mode_now,
             out_ch.range_fault};
      sb.check_word(got);
    end
  end

  // Watchdog on cycles where no word moves
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [srcp_pkg::SENSOR_W-1:0] any_sample();
    return srcp_pkg::SENSOR_W'($urandom);
  endfunction

  // Send one tick word; bursts of random length with random gaps between
  task automatic send_tick(input bit lvl, input logic [srcp_pkg::SENSOR_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.button_level  <= lvl;
    in_ch.sensor_sample <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(lvl, smp);
    ticks_sent++;
  endtask

  // Hold the button for n_down ticks, then release with the given sample
  task automatic press_n(input int n_down, input logic [srcp_pkg::SENSOR_W-1:0] rel_smp);
    repeat (n_down) send_tick(1'b1, any_sample());
    send_tick(1'b0, rel_smp);
  endtask

  // Stop sending and wait until every owed word has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_hold_limit(input logic [srcp_pkg::HOLD_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.thr = v;
  endtask

  // One random action, weighted by the current mode
  task automatic random_action();
    int thr_eff;
    int pick;
    thr_eff = (sb.thr == 0) ? 1 : int'(sb.thr);
    pick    = $urandom_range(0, 99);
    if (sb.mode == srcp_pkg::MODE_RUN) begin
      if (pick < 55)      send_tick(1'b0, any_sample());
      else if (pick < 70) press_n($urandom_range(1, thr_eff), any_sample());
      else if (pick < 80) send_tick(1'($urandom_range(0, 1)), any_sample());
      else                press_n(thr_eff + $urandom_range(1, 3), any_sample());
    end else begin
      if (pick < 80)      press_n($urandom_range(1, thr_eff), any_sample());
      else if (pick < 90) send_tick(1'($urandom_range(0, 1)), any_sample());
      else                press_n(thr_eff + $urandom_range(1, 3), any_sample());
    end
  endtask

  // Main sequence
  initial begin
    logic [srcp_pkg::HOLD_W-1:0] phase_thr [5];
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.button_level  = 1'b0;
    in_ch.sensor_sample = '0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: mapping extremes and a short press at the reset hold limit
    send_tick(1'b0, '0);
    send_tick(1'b0, {srcp_pkg::SENSOR_W{1'b1}});
    press_n(1, any_sample());

    // directed: a full calibration pass at the shortest hold limit
    set_hold_limit(16'd1);
    press_n(2, any_sample());                   // long press enters setting minimum
    press_n(1, any_sample());                   // short press lowers minimum
    press_n(2, any_sample());                   // long press moves to setting maximum
    press_n(1, any_sample());                   // short press raises maximum
    press_n(2, {srcp_pkg::SENSOR_W{1'b1}});     // long press back to run, mapped at full scale
    send_tick(1'b0, '0);

    // random phases over several hold limits, zero among them
    phase_thr[0] = 16'd3;
    phase_thr[1] = 16'd0;
    phase_thr[2] = 16'd7;
    phase_thr[3] = 16'd1;
    phase_thr[4] = srcp_pkg::HOLD_W'($urandom_range(2, 12));
    foreach (phase_thr[p]) begin
      set_hold_limit(phase_thr[p]);
      begin : phase_run
        int stop_at;
        stop_at = ticks_sent + PHASE_TICKS;
        while (ticks_sent < stop_at) random_action();
      end
    end

    // a last stretch at a small limit
    set_hold_limit(16'd4);
    repeat (30) random_action();

    settle();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
